>>> sv/eased_timed_interpolator_unit_defines.svh
// Assertion macros for the eased timed interpolator.
// Used by the top level only; no other dependencies.
`ifndef EASED_TIMED_INTERPOLATOR_UNIT_DEFINES_SVH
`define EASED_TIMED_INTERPOLATOR_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ETI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ETI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/eti_pkg.sv
// Package for the eased timed interpolator: constants, state type, logistic table.
// No dependencies.
`timescale 1ns / 1ps
package eti_pkg;
    localparam int unsigned ValueFracBits = 16;
    localparam int unsigned SigDepth = 256;
    localparam int unsigned SigShift = $clog2(SigDepth);
    localparam logic [16:0] OneQ16 = 17'd65536;
    localparam logic [16:0] SnapQ16 = 17'd65209;
    localparam longint unsigned EQ32 = 64'd11674931555;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_POLL  = 2'd3;

    localparam logic [1:0] MODE_LIN  = 2'd0;
    localparam logic [1:0] MODE_CIRC = 2'd1;
    localparam logic [1:0] MODE_SIG  = 2'd2;

    localparam logic CFG_DURATION = 1'b0;
    localparam logic CFG_MODE     = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_EASE = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_MULA = 7'b0010000,
        S_MULB = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // Restoring long division, used only while building the table
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo, rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Product of two Q32 values
    function automatic longint unsigned mul_q32(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned ah, al, bh, bl;
        ah = a >> 32;
        al = a & 64'hFFFF_FFFF;
        bh = b >> 32;
        bl = b & 64'hFFFF_FFFF;
        return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
    endfunction

    // Logistic sample at z = 12*i/depth - 6: Q32 series for e^|z|, mirrored for negative z
    function automatic logic [16:0] sig_entry(input int unsigned idx);
        longint unsigned up, mid, mag, whole, frac, term, ez, one, s;
        bit nonneg;
        up = 64'(12 * idx);
        mid = 64'(6 * SigDepth);
        nonneg = (up >= mid);
        mag = nonneg ? up - mid : mid - up;
        whole = mag >> SigShift;
        frac = (mag & 64'(SigDepth - 1)) << (32 - SigShift);
        one = 64'd1 << 32;
        term = one;
        ez = one;
        for (int k = 1; k <= 24; k++) begin
            term = udiv64(mul_q32(term, frac), 64'(k));
            ez = ez + term;
        end
        for (longint unsigned k = 0; k < whole; k++) ez = mul_q32(ez, EQ32);
        s = udiv64(64'd65536 * ez + ((ez + one) >> 1), ez + one);
        return nonneg ? 17'(s) : 17'(64'd65536 - s);
    endfunction
endpackage

>>> sv/eased_timed_interpolator_unit.sv
// Eased timed interpolator top level: sequencer, shared subtractor, one multiplier.
// Uses eti_pkg and the assertion macro header.
// Per item: restoring divide, ease step, two multiplies, output load; circular mode adds a
// square root after the ease step, and zero duration skips the divide and the ease step. One
// item at a time, ready low while busy, so a new item is taken only after the last one's
// output load step; a stalled result only holds the next one in its output load step.
// Synchronous active-low reset clears control state, endpoints, the elapsed counter and config.
`timescale 1ns / 1ps
`include "eased_timed_interpolator_unit_defines.svh"
module eased_timed_interpolator_unit
    import eti_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] req_type, [33:2] from_value, [65:34] to_value, [66] use_given, rest zero
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] eased_fraction, [48:17] tween_value, [49] still_running, rest zero
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    t_state r_state;
    logic [15:0] r_duration, r_elapsed, r_latched;
    logic [1:0]  r_mode;
    logic signed [31:0] r_from, r_to, r_a, r_b;
    logic        r_pending;
    logic [1:0]  r_req;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;      // divide and sqrt remainder
    logic [33:0] r_root;     // sqrt root accumulator
    logic [33:0] r_rad;      // radicand
    logic [16:0] r_q;
    logic signed [49:0] r_acc;
    logic        r_ovalid, r_run;
    logic [16:0] r_ofrac;
    logic [31:0] r_oval;

    // shared subtractor and multiplier
    logic [33:0] sub_a, sub_b, sub_d;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    assign sub_d = sub_a - sub_b;
    assign mul_p = mul_a * mul_b;

    logic [16:0] sig_tab [SigDepth+1];
    for (genvar g = 0; g <= SigDepth; g++) begin : g_tab
        assign sig_tab[g] = sig_entry(g);
    end

    logic [15:0] e_clip;
    logic [8:0]  sig_idx;
    logic [16:0] q_raw;
    assign e_clip = (r_elapsed < r_latched) ? r_elapsed : r_latched;
    // progress never exceeds one, so the rounded index stays within the table
    assign sig_idx = 9'((25'(r_q) * 25'(SigDepth) + 25'd32768) >> 16);

    assign s_axis_tready = r_state[0];
    assign o_cfg_ready = r_state[0] && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'd0, r_run, r_oval, r_ofrac};

    // select shared unit operands per state
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        mul_a = '0;
        mul_b = '0;
        q_raw = r_q;
        unique case (r_state)
            S_DIV: begin
                sub_a = {r_rem[32:0], 1'b0};
                sub_b = {18'd0, r_latched};
            end
            S_SQRT: begin
                sub_a = {r_rem[31:0], r_rad[33:32]};
                sub_b = {r_root[31:0], 2'b01};
            end
            S_EASE: begin
                if (r_mode == MODE_SIG)
                    q_raw = sig_tab[sig_idx];
                mul_a = 33'(r_q);
                mul_b = 18'(r_q);
                sub_a = {r_q, 17'd0};
                sub_b = 34'(mul_p[33:0]);
            end
            S_MULA: begin
                mul_a = 33'(r_a);
                mul_b = 18'(OneQ16 - r_q);
            end
            S_MULB: begin
                mul_a = 33'(r_b);
                mul_b = $signed({1'b0, r_q});
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_duration <= '0; r_mode <= '0; r_elapsed <= '0; r_latched <= '0;
            r_from <= '0; r_to <= '0; r_pending <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_index == CFG_DURATION) r_duration <= i_cfg_data;
                        else r_mode <= i_cfg_data[1:0];
                    end
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req <= s_axis_tdata[1:0];
                        r_a <= r_from;
                        r_b <= r_to;
                        unique case (s_axis_tdata[1:0])
                            REQ_START: begin
                                r_from <= s_axis_tdata[33:2];
                                r_to <= s_axis_tdata[65:34];
                                r_a <= s_axis_tdata[33:2];
                                r_b <= s_axis_tdata[65:34];
                                r_latched <= r_duration;
                                r_elapsed <= '0;
                                r_pending <= 1'b1;
                            end
                            REQ_TICK: if (r_elapsed != 16'hFFFF) r_elapsed <= r_elapsed + 16'd1;
                            REQ_QUERY: if (s_axis_tdata[66]) begin
                                r_a <= s_axis_tdata[33:2];
                                r_b <= s_axis_tdata[65:34];
                            end
                            default: ;
                        endcase
                        r_rem <= '0;
                        r_q <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit of e * 2^16 over dur per cycle
                    if (r_latched == '0) begin
                        r_q <= OneQ16;
                        r_acc <= '0;
                        r_state <= S_MULA;
                    end else if (r_cnt == 5'd17) begin
                        r_state <= S_EASE;
                    end else begin
                        if (r_cnt == 5'd0) begin
                            // full elapsed time gives the top quotient bit and no remainder
                            if (e_clip == r_latched) begin
                                r_rem <= '0;
                                r_q <= 17'd1;
                            end else r_rem <= 33'(e_clip);
                        end else if (!sub_d[33]) begin
                            r_rem <= sub_d[32:0];
                            r_q <= {r_q[15:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[31:0], 1'b0};
                            r_q <= {r_q[15:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_EASE: begin
                    r_acc <= '0;
                    if (r_mode == MODE_CIRC) begin
                        r_rad <= sub_d;
                        r_rem <= '0;
                        r_root <= '0;
                        r_cnt <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_q <= (q_raw >= SnapQ16) ? OneQ16 : q_raw;
                        r_state <= S_MULA;
                    end
                end
                S_SQRT: begin
                    // two radicand bits per cycle, one root bit
                    r_rad <= {r_rad[31:0], 2'b00};
                    if (!sub_d[33]) begin
                        r_rem <= sub_d[32:0];
                        r_root <= {r_root[32:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_rad[33:32]};
                        r_root <= {r_root[32:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_q <= ((!sub_d[33] ? {r_root[15:0], 1'b1} : {r_root[15:0], 1'b0})
                                >= SnapQ16) ? OneQ16
                               : (!sub_d[33] ? {r_root[15:0], 1'b1} : {r_root[15:0], 1'b0});
                        r_state <= S_MULA;
                    end
                end
                S_MULA: begin
                    r_acc <= 50'(mul_p);
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_acc <= r_acc + 50'(mul_p) + 50'sd32768;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // load the output register once the previous result has left
                    if (!r_ovalid || m_axis_tready) begin
                        r_ofrac <= r_q;
                        r_oval <= r_acc[47:16];
                        r_run <= 1'b0;
                        if (r_req == REQ_POLL) begin
                            if (r_q != OneQ16) r_run <= 1'b1;
                            else if (r_pending) begin
                                r_pending <= 1'b0;
                                r_run <= 1'b1;
                            end
                        end
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ETI_ASSERT_IMP(a_frac_range, i_clk, i_rst_n, r_ovalid, r_ofrac <= OneQ16,
        "eased fraction above one")
    `ETI_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, !r_state[0], !s_axis_tready,
        "input ready while busy")
    `ETI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !m_axis_tready,
        r_ovalid && $stable(r_ofrac), "result dropped under stall")
endmodule
